@@ rtl/i2c_master_byte_engine_defines.svh @@
// Assertion macros shared by the engine's modules.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define I2CM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("i2cm assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define I2CM_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT(label, clk, rst, prop)
`define I2CM_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

   // One input beat: a command offer plus the sampled bus levels.
   typedef struct packed {
      logic       cmd_valid;
      logic       op;
      logic       start_first;
      logic       stop_after;
      logic [7:0] tx_data;
      logic       nack_to_send;
      logic       scl_level;
      logic       sda_level;
   } req_type;

   // One result beat, produced for every input beat.
   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       ack_seen;
   } rsp_type;

   // A classified beat as it waits in the queue between front and back.
   typedef struct packed {
      logic       cmd_valid;
      logic       op;
      logic       want_start;
      logic       stop_after;
      logic       nack_to_send;
      logic [7:0] shift_init;
      logic       scl_level;
      logic       sda_level;
   } q_item_type;

   // Command bits held for the duration of a byte.
   typedef struct packed {
      logic op;
      logic stop_after;
      logic nack_to_send;
   } held_type;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_RS_DLY1  = 5'd1,
      PH_RS_WAIT  = 5'd2,
      PH_RS_DLY2  = 5'd3,
      PH_ST_DLY   = 5'd4,
      PH_BIT_DLY1 = 5'd5,
      PH_BIT_WAIT = 5'd6,
      PH_BIT_DLY2 = 5'd7,
      PH_BIT_DLY3 = 5'd8,
      PH_SP_DLY1  = 5'd9,
      PH_SP_WAIT  = 5'd10,
      PH_SP_DLY2  = 5'd11,
      PH_SP_DLY3  = 5'd12
   } phase_type;

   localparam int          QUEUE_DEPTH       = 2;
   localparam logic [15:0] HALF_DELAY_RESET  = 16'd2;
   localparam logic [3:0]  DATA_BITS         = 4'd8;
   localparam logic [3:0]  FRAME_BITS        = 4'd9;

endpackage

@@ rtl/i2cm_front.sv @@
`include "i2c_master_byte_engine_defines.svh"

module i2cm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  i2cm_pkg::req_type    req_data,
   output logic                 q_valid,
   output i2cm_pkg::q_item_type q_item,
   input  logic                 q_pop
);

   i2cm_pkg::q_item_type entry_ff [i2cm_pkg::QUEUE_DEPTH];
   i2cm_pkg::q_item_type item_c;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;

   // Classify the beat: a start only applies to writes, reads shift in from zero.
   always_comb begin
      item_c.cmd_valid    = req_data.cmd_valid;
      item_c.op           = req_data.op;
      item_c.want_start   = ~req_data.op & req_data.start_first;
      item_c.stop_after   = req_data.stop_after;
      item_c.nack_to_send = req_data.nack_to_send;
      item_c.shift_init   = req_data.op ? 8'd0 : req_data.tx_data;
      item_c.scl_level    = req_data.scl_level;
      item_c.sda_level    = req_data.sda_level;
   end

   // The queue is full when both entries hold a beat.
   assign req_stall = (count_ff == 2'(i2cm_pkg::QUEUE_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_c;
      end
   end

   `I2CM_ASSERT(a_count_bound, clock, reset, count_ff <= 2'(i2cm_pkg::QUEUE_DEPTH))
   `I2CM_ASSERT(a_pop_only_valid, clock, reset, !q_pop || q_valid)
   `I2CM_ASSERT_NEXT(a_full_holds, clock, reset, req_stall && !q_pop, req_stall)

endmodule

@@ rtl/i2cm_back.sv @@
`include "i2c_master_byte_engine_defines.svh"

module i2cm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 q_valid,
   input  i2cm_pkg::q_item_type q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output i2cm_pkg::rsp_type    rsp_data
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   i2cm_pkg::held_type  held_ff, held_in;
   i2cm_pkg::rsp_type   rsp_data_ff, rsp_next;
   logic [15:0]         half_delay_ff;
   logic [15:0]         delay_ff, delay_in, delay_load;
   logic [3:0]          bit_ff, bit_in, bit_next;
   logic [7:0]          shift_ff, shift_in;
   logic [7:0]          rx_ff, rx_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic                started_ff, started_in;
   logic                ack_ff, ack_in;
   logic                done_c;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                step;
   logic                delay_end;
   logic                load_delay;

   // Level to put on SDA for a bit slot; the ninth slot is the ACK slot.
   function automatic logic bit_level(input logic [3:0] idx, input logic op,
                                      input logic nack, input logic [7:0] data);
      logic lvl;
      if (idx >= i2cm_pkg::DATA_BITS) begin
         lvl = op ? nack : 1'b1;
      end else if (op) begin
         lvl = 1'b1;
      end else begin
         lvl = data[3'd7 - idx[2:0]];
      end
      return lvl;
   endfunction

   function automatic logic is_delay(input i2cm_pkg::phase_type ph);
      logic d;
      case (ph)
         i2cm_pkg::PH_RS_DLY1, i2cm_pkg::PH_RS_DLY2, i2cm_pkg::PH_ST_DLY,
         i2cm_pkg::PH_BIT_DLY1, i2cm_pkg::PH_BIT_DLY2, i2cm_pkg::PH_BIT_DLY3,
         i2cm_pkg::PH_SP_DLY1, i2cm_pkg::PH_SP_DLY2, i2cm_pkg::PH_SP_DLY3: d = 1'b1;
         default: d = 1'b0;
      endcase
      return d;
   endfunction

   // A beat is processed whenever the output register can take its result.
   assign step       = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign q_pop      = step;
   assign delay_end  = (delay_ff <= 16'd1);
   assign delay_load = (half_delay_ff == 16'd0) ? 16'd1 : half_delay_ff;
   assign bit_next   = bit_ff + 4'd1;
   assign load_delay = step & is_delay(phase_in) & (phase_in != phase_ff);

   // Next phase of the bit sequencer.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            i2cm_pkg::PH_IDLE: begin
               if (q_item.cmd_valid) begin
                  if (q_item.want_start) begin
                     phase_in = started_ff ? i2cm_pkg::PH_RS_DLY1 : i2cm_pkg::PH_ST_DLY;
                  end else begin
                     phase_in = i2cm_pkg::PH_BIT_DLY1;
                  end
               end
            end
            i2cm_pkg::PH_RS_WAIT: begin
               if (q_item.scl_level) phase_in = i2cm_pkg::PH_RS_DLY2;
            end
            i2cm_pkg::PH_BIT_WAIT: begin
               if (q_item.scl_level) phase_in = i2cm_pkg::PH_BIT_DLY2;
            end
            i2cm_pkg::PH_SP_WAIT: begin
               if (q_item.scl_level) phase_in = i2cm_pkg::PH_SP_DLY2;
            end
            i2cm_pkg::PH_RS_DLY1: begin
               if (delay_end) phase_in = i2cm_pkg::PH_RS_WAIT;
            end
            i2cm_pkg::PH_RS_DLY2: begin
               if (delay_end) phase_in = i2cm_pkg::PH_ST_DLY;
            end
            i2cm_pkg::PH_ST_DLY: begin
               if (delay_end) phase_in = i2cm_pkg::PH_BIT_DLY1;
            end
            i2cm_pkg::PH_BIT_DLY1: begin
               if (delay_end) phase_in = i2cm_pkg::PH_BIT_WAIT;
            end
            i2cm_pkg::PH_BIT_DLY2: begin
               if (delay_end) phase_in = i2cm_pkg::PH_BIT_DLY3;
            end
            i2cm_pkg::PH_BIT_DLY3: begin
               if (delay_end) begin
                  if (bit_next < i2cm_pkg::FRAME_BITS) begin
                     phase_in = i2cm_pkg::PH_BIT_DLY1;
                  end else if (held_ff.stop_after) begin
                     phase_in = i2cm_pkg::PH_SP_DLY1;
                  end else begin
                     phase_in = i2cm_pkg::PH_IDLE;
                  end
               end
            end
            i2cm_pkg::PH_SP_DLY1: begin
               if (delay_end) phase_in = i2cm_pkg::PH_SP_WAIT;
            end
            i2cm_pkg::PH_SP_DLY2: begin
               if (delay_end) phase_in = i2cm_pkg::PH_SP_DLY3;
            end
            i2cm_pkg::PH_SP_DLY3: begin
               if (delay_end) phase_in = i2cm_pkg::PH_IDLE;
            end
            default: phase_in = i2cm_pkg::PH_IDLE;
         endcase
      end
   end

   // Line drives, shift register, counters and status for this beat.
   always_comb begin
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      started_in = started_ff;
      held_in    = held_ff;
      ack_in     = ack_ff;
      rx_in      = rx_ff;
      delay_in   = delay_ff;
      done_c     = 1'b0;
      if (step) begin
         if (is_delay(phase_ff)) begin
            delay_in = delay_end ? 16'd0 : delay_ff - 16'd1;
         end
         case (phase_ff)
            i2cm_pkg::PH_IDLE: begin
               if (q_item.cmd_valid) begin
                  held_in.op           = q_item.op;
                  held_in.stop_after   = q_item.stop_after;
                  held_in.nack_to_send = q_item.nack_to_send;
                  shift_in             = q_item.shift_init;
                  bit_in               = 4'd0;
                  if (q_item.want_start) begin
                     // A fresh start pulls SDA low; a repeated start releases it first.
                     sda_in = ~started_ff;
                  end else begin
                     sda_in = ~bit_level(4'd0, q_item.op, q_item.nack_to_send,
                                         q_item.shift_init);
                  end
               end
            end
            i2cm_pkg::PH_BIT_WAIT: begin
               if (q_item.scl_level) begin
                  if (bit_ff < i2cm_pkg::DATA_BITS) begin
                     if (held_ff.op) shift_in = {shift_ff[6:0], q_item.sda_level};
                  end else if (!held_ff.op) begin
                     ack_in = q_item.sda_level;
                  end
               end
            end
            i2cm_pkg::PH_RS_DLY1, i2cm_pkg::PH_BIT_DLY1, i2cm_pkg::PH_SP_DLY1: begin
               if (delay_end) scl_in = 1'b0;
            end
            i2cm_pkg::PH_RS_DLY2: begin
               if (delay_end) sda_in = 1'b1;
            end
            i2cm_pkg::PH_ST_DLY: begin
               if (delay_end) begin
                  scl_in     = 1'b1;
                  started_in = 1'b1;
                  bit_in     = 4'd0;
                  sda_in     = ~bit_level(4'd0, held_ff.op, held_ff.nack_to_send, shift_ff);
               end
            end
            i2cm_pkg::PH_BIT_DLY2: begin
               if (delay_end) scl_in = 1'b1;
            end
            i2cm_pkg::PH_BIT_DLY3: begin
               if (delay_end) begin
                  bit_in = bit_next;
                  if (bit_next < i2cm_pkg::FRAME_BITS) begin
                     sda_in = ~bit_level(bit_next, held_ff.op, held_ff.nack_to_send, shift_ff);
                  end else if (held_ff.stop_after) begin
                     sda_in = 1'b1;
                  end else begin
                     if (held_ff.op) rx_in = shift_ff;
                     done_c = 1'b1;
                  end
               end
            end
            i2cm_pkg::PH_SP_DLY2: begin
               if (delay_end) sda_in = 1'b0;
            end
            i2cm_pkg::PH_SP_DLY3: begin
               if (delay_end) begin
                  started_in = 1'b0;
                  if (held_ff.op) rx_in = shift_ff;
                  done_c = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (load_delay) delay_in = delay_load;
      end
   end

   // Result of this beat.
   always_comb begin
      rsp_next.scl_drive_low = scl_in;
      rsp_next.sda_drive_low = sda_in;
      rsp_next.busy_res      = (phase_in != i2cm_pkg::PH_IDLE);
      rsp_next.done_res      = done_c;
      rsp_next.rx_data       = rx_in;
      rsp_next.ack_seen      = ack_in;
      rsp_valid_in           = step | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         held_ff       <= '0;
         half_delay_ff <= i2cm_pkg::HALF_DELAY_RESET;
         delay_ff      <= 16'd0;
         bit_ff        <= 4'd0;
         shift_ff      <= 8'd0;
         rx_ff         <= 8'd0;
         scl_ff        <= 1'b0;
         sda_ff        <= 1'b0;
         started_ff    <= 1'b0;
         ack_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         if (csr_wr_en) half_delay_ff <= csr_wr_data;
         delay_ff      <= delay_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         rx_ff         <= rx_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         started_ff    <= started_in;
         ack_ff        <= ack_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Output payload register; loaded only when a beat is processed.
   always_ff @(posedge clock) begin
      if (step) rsp_data_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `I2CM_ASSERT(a_done_not_busy, clock, reset,
                !rsp_valid_ff || !rsp_data_ff.done_res || !rsp_data_ff.busy_res)
   `I2CM_ASSERT(a_delay_nonzero, clock, reset, !is_delay(phase_ff) || delay_ff != 16'd0)
   `I2CM_ASSERT_NEXT(a_phase_holds, clock, reset, !step, $stable(phase_ff))
   `I2CM_ASSERT(a_bit_bound, clock, reset, bit_ff <= i2cm_pkg::FRAME_BITS)

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// Byte-level I2C master: one input beat per bus tick, one result beat per input beat.
// A beat is first written into the queue; the back step then loads the result register from
// it once the output can take it. Throughput: 1 beat per cycle while rsp_stall does not hold
// the output register, as the back sequencer steps once per beat. Reset (synchronous, active
// high): sequencer idle, lines released, queue empty, half_delay = 2, byte and ACK cleared.
module i2c_master_byte_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   logic                 q_valid;
   logic                 q_pop;
   i2cm_pkg::q_item_type q_item;

   // Front: accepts and classifies beats into a two-entry queue.
   i2cm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // Back: runs the bus sequencer and registers each result.
   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
